// ===== rtl/btoi_pkg.sv =====
// Package with shared types, constants and helpers for the base-N text to integer block.
`default_nettype none

package btoi_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int NUM_SYM     = 16;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 5;
    localparam int DIG_W       = 4;
    localparam int ACC_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
    localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
    localparam logic [SYM_W-1:0] CH_NUL   = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN      = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0] ch;
        logic             last;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    base_valid;
    } t_out;

    // configured base as seen by the conversion core
    typedef struct packed {
        logic [NUM_SYM-1:0][SYM_W-1:0] sym;
        logic [LEN_W-1:0]              len;
        logic                          ok;
    } t_base;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/btoi_cfg.sv =====
// Configuration registers and base validity check.
`default_nettype none

module btoi_cfg
    import btoi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output      t_base                 o_base
);

    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;
    logic [LEN_W-1:0]      r_len;
    logic                  w_ok;
    logic [NUM_SYM-1:0][SYM_W-1:0] w_sym;

    assign w_sym = {r_sym_high, r_sym_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_len      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SYM_LOW:  r_sym_low  <= i_cfg_data;
                    CFG_SYM_HIGH: r_sym_high <= i_cfg_data;
                    CFG_LEN:      r_len      <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // length range, forbidden symbols, then pairwise duplicates among symbols in use
    always_comb begin
        w_ok = (r_len >= LEN_W'(2)) && (r_len <= LEN_W'(MAX_SYMBOLS));
        for (int a = 0; a < NUM_SYM; a++) begin
            if (LEN_W'(a) < r_len) begin
                if ((w_sym[a] == CH_NUL) || (w_sym[a] == CH_PLUS) || (w_sym[a] == CH_MINUS))
                    w_ok = 1'b0;
                for (int b = a + 1; b < NUM_SYM; b++) begin
                    if ((LEN_W'(b) < r_len) && (w_sym[b] == w_sym[a]))
                        w_ok = 1'b0;
                end
            end
        end
    end

    assign o_base.sym = w_sym;
    assign o_base.len = r_len;
    assign o_base.ok  = w_ok;

endmodule

`default_nettype wire

// ===== rtl/btoi_core.sv =====
// Conversion core: phase, sign and accumulator state with symbol lookup.
`default_nettype none

module btoi_core
    import btoi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire t_in   i_item,
    input  wire t_base i_base,
    output      t_out  o_result
);

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_DIGIT = 2'd1,
        PH_STOP  = 2'd2,
        PH_SPARE = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [ACC_W-1:0] r_acc, n_acc;

    logic [LEN_W-1:0] w_used;
    logic             w_hit;
    logic [DIG_W-1:0] w_dig;
    logic [ACC_W-1:0] w_acc_step;
    logic [ACC_W-1:0] w_value;

    assign w_used = (i_base.len > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : i_base.len;

    // lowest matching symbol position wins
    always_comb begin
        w_hit = 1'b0;
        w_dig = '0;
        for (int k = NUM_SYM - 1; k >= 0; k--) begin
            if ((LEN_W'(k) < w_used) && (i_base.sym[k] == i_item.ch)) begin
                w_hit = 1'b1;
                w_dig = DIG_W'(k);
            end
        end
    end

    assign w_acc_step = ACC_W'(r_acc * {{(ACC_W-LEN_W){1'b0}}, i_base.len})
                      + {{(ACC_W-DIG_W){1'b0}}, w_dig};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        unique case (r_phase)
            PH_SPACE: begin
                if (is_space(i_item.ch)) begin
                    n_phase = PH_SPACE;
                end else if (i_item.ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_DIGIT;
                end else if (i_item.ch == CH_PLUS) begin
                    n_phase = PH_DIGIT;
                end else if (w_hit) begin
                    n_phase = PH_DIGIT;
                    n_acc   = w_acc_step;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_DIGIT: begin
                if (w_hit)
                    n_acc = w_acc_step;
                else
                    n_phase = PH_STOP;
            end
            default: ;
        endcase
    end

    assign w_value = n_neg ? (ACC_W'(0) - n_acc) : n_acc;
    assign o_result.value      = i_base.ok ? w_value : '0;
    assign o_result.base_valid = i_base.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (i_advance) begin
            // end of string: start the next one from a clean state
            if (i_item.last) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/base_n_text_to_integer.sv =====
// Top level of the base-N text to integer converter.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in  (t_in: ch, last)
//   out      output     o_out_valid / i_out_stall o_out (t_out: value, base_valid)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One character per cycle unless a last character waits for a held result: a
// transaction lands in the input register, the core updates accumulator state
// from it in the next cycle and a last character loads the result register, which
// raises o_out_valid. The accumulator feedback (symbol match, 32x5 multiply, add) sets
// the cycle. Base validity is decoded combinationally from the configuration registers.
// Reset clears all configuration to zero; a held result stalls only last characters.
`default_nettype none

module base_n_text_to_integer
    import btoi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in                   i_in,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out                  o_out,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_base w_base;
    t_out  w_result;
    t_in   r_item;
    logic  r_item_vld;
    t_out  r_out;
    logic  r_out_vld;
    logic  w_out_free;
    logic  w_advance;

    assign o_cfg_ready = 1'b1;

    btoi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_base      (w_base)
    );

    btoi_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_item),
        .i_base    (w_base),
        .o_result  (w_result)
    );

    assign w_out_free = !r_out_vld || !i_out_stall;
    // a last character waits for room in the result register
    assign w_advance  = r_item_vld && (!r_item.last || w_out_free);
    assign o_in_stall = r_item_vld && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (!o_in_stall)
                r_item_vld <= i_in_valid;
            if (w_advance && r_item.last)
                r_out_vld <= 1'b1;
            else if (!i_out_stall)
                r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid)
            r_item <= i_in;
        if (w_advance && r_item.last)
            r_out <= w_result;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/tb_base_n_text_to_integer.sv =====
// Testbench for the base-N text to integer converter: directed and random strings against a predictor.
module tb_base_n_text_to_integer;
    timeunit 1ns;
    timeprecision 1ps;

    import btoi_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        SCAN_WS,
        SCAN_DIGITS,
        SCAN_STOPPED
    } t_scan_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor copy of the configuration and conversion state
    logic [CFG_DATA_W-1:0] cfg_sym_low  = '0;
    logic [CFG_DATA_W-1:0] cfg_sym_high = '0;
    logic [LEN_W-1:0]      cfg_len      = '0;
    t_scan_phase           scan_phase   = SCAN_WS;
    logic                  scan_neg     = 1'b0;
    logic [ACC_W-1:0]      scan_accum   = '0;

    t_out expected_conversions[$];
    int   error_count  = 0;
    int   chars_sent   = 0;
    int   in_idle_pct  = 0;
    int   out_idle_pct = 0;

    base_n_text_to_integer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [SYM_W-1:0] symbol_at(input int k);
        logic [2*CFG_DATA_W-1:0] all_syms;
        all_syms = {cfg_sym_high, cfg_sym_low};
        return all_syms[SYM_W*k +: SYM_W];
    endfunction

    function automatic logic base_is_valid();
        int n;
        n = int'(cfg_len);
        if (n < 2 || n > MAX_SYMBOLS)
            return 1'b0;
        for (int a = 0; a < n; a++) begin
            if (symbol_at(a) == CH_NUL || symbol_at(a) == CH_PLUS || symbol_at(a) == CH_MINUS)
                return 1'b0;
            for (int b = a + 1; b < n; b++)
                if (symbol_at(b) == symbol_at(a))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // lookup uses at most MAX_SYMBOLS symbols even when the length is larger
    task automatic take_digit(input logic [SYM_W-1:0] c);
        int n;
        int digit;
        n = (int'(cfg_len) > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(cfg_len);
        digit = -1;
        for (int k = n - 1; k >= 0; k--)
            if (symbol_at(k) == c)
                digit = k;
        if (digit < 0)
            scan_phase = SCAN_STOPPED;
        else
            scan_accum = scan_accum * {{(ACC_W-LEN_W){1'b0}}, cfg_len} + ACC_W'(digit);
    endtask

    task automatic convert_char(input logic [SYM_W-1:0] c, input logic lst);
        t_out res;
        logic ok;
        case (scan_phase)
            SCAN_WS: begin
                if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
                    // skip leading whitespace
                end else if (c == CH_MINUS) begin
                    scan_neg   = 1'b1;
                    scan_phase = SCAN_DIGITS;
                end else if (c == CH_PLUS) begin
                    scan_phase = SCAN_DIGITS;
                end else begin
                    scan_phase = SCAN_DIGITS;
                    take_digit(c);
                end
            end
            SCAN_DIGITS: take_digit(c);
            default: ;
        endcase
        if (lst) begin
            ok = base_is_valid();
            res.base_valid = ok;
            if (!ok)
                res.value = '0;
            else if (scan_neg)
                res.value = -scan_accum;
            else
                res.value = scan_accum;
            expected_conversions.push_back(res);
            scan_phase = SCAN_WS;
            scan_neg   = 1'b0;
            scan_accum = '0;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_conversions.size() == 0) begin
                flag_error($sformatf("unexpected result value=%0d base_valid=%0b",
                                     o_out.value, o_out.base_valid));
            end else begin
                want = expected_conversions.pop_front();
                if (o_out.value !== want.value)
                    flag_error($sformatf("value: got %0d, want %0d", o_out.value, want.value));
                if (o_out.base_valid !== want.base_valid)
                    flag_error($sformatf("base_valid: got %0b, want %0b",
                                         o_out.base_valid, want.base_valid));
            end
        end
    end

    task automatic send_char(input logic [SYM_W-1:0] c, input logic lst);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in.ch    = c;
        i_in.last  = lst;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        convert_char(c, lst);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    // hold the input until every pending conversion has come out
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_conversions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_SYM_LOW:  cfg_sym_low  = data;
            CFG_SYM_HIGH: cfg_sym_high = data;
            CFG_LEN:      cfg_len      = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_base(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input logic [LEN_W-1:0] len);
        quiesce();
        write_reg(CFG_SYM_LOW, lo);
        write_reg(CFG_SYM_HIGH, hi);
        write_reg(CFG_LEN, CFG_DATA_W'(len));
    endtask

    function automatic logic [SYM_W-1:0] random_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + SYM_W'(k);
    endfunction

    task automatic pick_random_base();
        logic [SYM_W-1:0]          syms[MAX_SYMBOLS];
        bit                        taken[256];
        logic [2*CFG_DATA_W-1:0]   packed_syms;
        logic [LEN_W-1:0]          len;
        logic [SYM_W-1:0]          c;
        int                        roll;
        int                        i;
        int                        j;
        taken = '{default: 1'b0};
        roll  = $urandom_range(0, 99);
        len   = (roll < 20) ? LEN_W'(2) : (roll < 40) ? LEN_W'(16)
                                                     : LEN_W'($urandom_range(2, 16));
        for (i = 0; i < MAX_SYMBOLS; i++) begin
            do
                c = SYM_W'($urandom_range(1, 255));
            while (taken[c] || c == CH_PLUS || c == CH_MINUS);
            taken[c] = 1'b1;
            syms[i]  = c;
        end
        // break the base now and then
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(0, 4))
                0: len = LEN_W'($urandom_range(0, 1));
                1: len = LEN_W'($urandom_range(17, 31));
                2: begin
                    i = $urandom_range(0, len - 2);
                    j = $urandom_range(i + 1, len - 1);
                    syms[j] = syms[i];
                end
                3: begin
                    i = $urandom_range(0, len - 1);
                    case ($urandom_range(0, 2))
                        0: syms[i] = CH_PLUS;
                        1: syms[i] = CH_MINUS;
                        default: syms[i] = CH_NUL;
                    endcase
                end
                default: begin
                    syms = '{default: 8'hFF};
                    len  = LEN_W'(16);
                end
            endcase
        end
        for (i = 0; i < MAX_SYMBOLS; i++)
            packed_syms[SYM_W*i +: SYM_W] = syms[i];
        set_base(packed_syms[CFG_DATA_W-1:0], packed_syms[2*CFG_DATA_W-1:CFG_DATA_W], len);
    endtask

    task automatic send_random_string();
        logic [SYM_W-1:0] text[$];
        int               n_used;
        n_used = (int'(cfg_len) > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(cfg_len);
        if ($urandom_range(99) < 80) begin
            repeat ($urandom_range(0, 2)) text.push_back(random_space());
            case ($urandom_range(0, 2))
                1: text.push_back(CH_PLUS);
                2: text.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 12)) begin
                if (n_used > 0)
                    text.push_back(symbol_at($urandom_range(0, n_used - 1)));
                else
                    text.push_back(SYM_W'($urandom_range(1, 255)));
            end
            if ($urandom_range(9) == 0)
                text.push_back(SYM_W'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 4))
                    0: text.push_back(CH_PLUS);
                    1: text.push_back(CH_MINUS);
                    2: text.push_back(random_space());
                    default: text.push_back(SYM_W'($urandom_range(1, 255)));
                endcase
            end
        end
        for (int k = 0; k < text.size(); k++)
            send_char(text[k], k == text.size() - 1);
    endtask

    // all registers still at reset: length 0 is not a valid base
    task automatic test_reset_base();
        send_text("7");
    endtask

    task automatic test_hex_extremes();
        set_base(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, LEN_W'(16));
        send_char(CH_TAB, 1'b0);
        send_char(8'd10, 1'b0);
        send_char(8'd11, 1'b0);
        send_char(8'd12, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_text("-80000000");
        send_text("+F");
    endtask

    task automatic test_sign_after_digits();
        send_text("1-7");
    endtask

    task automatic test_zero_char();
        send_char(CH_NUL, 1'b0);
        send_char(8'h01, 1'b1);
    endtask

    task automatic test_invalid_bases();
        set_base(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, LEN_W'(17));
        send_text("1");
        set_base('1, '1, LEN_W'(16));
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_config_mid_string();
        set_base(64'h3130, '0, LEN_W'(2));
        send_char("1", 1'b0);
        send_char("1", 1'b0);
        quiesce();
        write_reg(CFG_SYM_LOW, 64'h32_3130);
        write_reg(CFG_LEN, CFG_DATA_W'(3));
        send_char("2", 1'b1);
    endtask

    task automatic test_random(input int n_chars, input int in_pct, input int out_pct);
        int start;
        int strings_left;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        start        = chars_sent;
        strings_left = 0;
        while (chars_sent - start < n_chars) begin
            if (strings_left == 0) begin
                pick_random_base();
                strings_left = $urandom_range(5, 25);
            end
            if ($urandom_range(49) == 0)
                quiesce();
            send_random_string();
            strings_left--;
        end
    endtask

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        in_idle_pct  = 35;
        out_idle_pct = 59;
        test_reset_base();
        test_hex_extremes();
        test_sign_after_digits();
        test_zero_char();
        test_invalid_bases();
        test_config_mid_string();

        test_random(470, 35, 59);
        test_random(470, 59, 35);
        test_random(460, 0, 0);

        quiesce();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
